// ===== src/qs_pkg.sv =====
// ----------------------------------------------------------------------------
// qs_pkg: shared types and constants for the quaternion slerp block
// Payload structs, fixed-point constants and polynomial coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package qs_pkg;

	localparam int ACOS_STEPS = 20;
	localparam int SIN_LAT    = 6;
	localparam int QBITS      = 47;
	localparam int DIV_LAT    = QBITS + 1;

	localparam logic [19:0] ANG_HALF = 20'h80000;
	localparam logic [20:0] ANG_PI   = 21'h100000;
	localparam logic [16:0] T_ONE    = 17'h10000;

	localparam logic signed [33:0] ONE30      = 34'sh040000000;
	localparam logic signed [33:0] NEAR_LIMIT = 34'sd98304;
	localparam logic [46:0]        WEIGHT_MAX = 47'h400000000000;

	localparam logic [31:0] C1 = 32'd1686629713;
	localparam logic [31:0] C3 = 32'd693598668;
	localparam logic [31:0] C5 = 32'd85569306;
	localparam logic [31:0] C7 = 32'd5026995;
	localparam logic [31:0] C9 = 32'd172270;

	// Horner order after the innermost coefficient
	localparam logic [31:0] HORNER [4] = '{C7, C5, C3, C1};

	typedef struct packed {
		logic        [16:0] blend;
		logic signed [15:0] start_q0;
		logic signed [15:0] start_q1;
		logic signed [15:0] start_q2;
		logic signed [15:0] start_q3;
		logic signed [15:0] end_q0;
		logic signed [15:0] end_q1;
		logic signed [15:0] end_q2;
		logic signed [15:0] end_q3;
	} in_t;

	typedef struct packed {
		logic signed [15:0] out_q0;
		logic signed [15:0] out_q1;
		logic signed [15:0] out_q2;
		logic signed [15:0] out_q3;
	} out_t;

	// Per-item data that rides along the angle and weight pipelines
	typedef struct packed {
		logic [16:0]       t;
		logic [3:0][15:0]  p;
		logic [3:0][16:0]  q;
		logic [31:0]       dot;
		logic              slerp;
	} side_t;

endpackage

`default_nettype wire

// ===== src/qs_sin.sv =====
// ----------------------------------------------------------------------------
// qs_sin: pipelined sine of a binary angle
// Folds [0, pi] onto [0, pi/2] and evaluates the odd polynomial in Q.30,
// one multiply per stage, six stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_sin (
	input  logic        clk,
	input  logic        en,
	input  logic [20:0] angle,
	output logic [30:0] sine
);

	logic [20:0] fold;
	logic [30:0] z;
	logic [61:0] zz;
	logic [30:0] z_s  [5];
	logic [30:0] z2_s [4];
	logic [31:0] hs_s [4];
	logic [62:0] fprod;
	logic [30:0] sine_s;

	assign fold = (angle > 21'(qs_pkg::ANG_HALF)) ? qs_pkg::ANG_PI - angle : angle;
	assign z    = {fold[19:0], 11'b0};
	assign zz   = 62'(z) * 62'(z);

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0]  <= z;
			z2_s[0] <= zz[60:30];
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_horner
		logic [31:0] acc;
		logic [62:0] prod;

		if (k == 0) begin : g_first
			assign acc = qs_pkg::C9;
		end else begin : g_next
			assign acc = hs_s[k-1];
		end

		assign prod = 63'(z2_s[k]) * 63'(acc);

		always_ff @(posedge clk) begin
			if (en) begin
				hs_s[k]  <= qs_pkg::HORNER[k] - prod[61:30];
				z_s[k+1] <= z_s[k];
			end
		end

		if (k < 3) begin : g_z2
			always_ff @(posedge clk) begin
				if (en) begin
					z2_s[k+1] <= z2_s[k];
				end
			end
		end
	end

	assign fprod = 63'(z_s[4]) * 63'(hs_s[3]);

	always_ff @(posedge clk) begin
		if (en) begin
			sine_s <= fprod[60:30];
		end
	end

	assign sine = sine_s;

endmodule

`default_nettype wire

// ===== src/qs_div.sv =====
// ----------------------------------------------------------------------------
// qs_div: pipelined weight divider
// Forms floor((num << 30) / den) one quotient bit per stage and saturates
// the weight at 2^46.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_div (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] num,
	input  logic [30:0] den,
	output logic [46:0] quo
);

	logic [30:0] rem_s  [qs_pkg::QBITS+1];
	logic [46:0] quo_s  [qs_pkg::QBITS+1];
	logic        ovf_s  [qs_pkg::QBITS+1];
	logic [16:0] bits_s [qs_pkg::QBITS];
	logic [30:0] den_s  [qs_pkg::QBITS];

	// Upper dividend bits go straight into the remainder; a quotient past
	// 47 bits shows up here as overflow.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= 31'(num[30:17]);
			ovf_s[0]  <= 31'(num[30:17]) >= den;
			quo_s[0]  <= '0;
			bits_s[0] <= num[16:0];
			den_s[0]  <= den;
		end
	end

	for (genvar k = 0; k < qs_pkg::QBITS; k++) begin : g_step
		logic [31:0] trial;
		logic        ge;
		logic [31:0] diff;

		assign trial = {rem_s[k], bits_s[k][16]};
		assign ge    = trial >= {1'b0, den_s[k]};
		assign diff  = trial - {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[30:0] : trial[30:0];
				quo_s[k+1] <= {quo_s[k][45:0], ge};
				ovf_s[k+1] <= ovf_s[k];
			end
		end

		if (k < qs_pkg::QBITS - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					bits_s[k+1] <= {bits_s[k][15:0], 1'b0};
					den_s[k+1]  <= den_s[k];
				end
			end
		end
	end

	assign quo = (ovf_s[qs_pkg::QBITS] || quo_s[qs_pkg::QBITS] > qs_pkg::WEIGHT_MAX) ?
		qs_pkg::WEIGHT_MAX : quo_s[qs_pkg::QBITS];

endmodule

`default_nettype wire

// ===== src/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp: fixed-point spherical linear interpolation
// Blends a start and an end unit quaternion (Q1.15) by t (Q1.16).
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat carries t and both quaternions; taken when in_valid and
//           in_ready are high at a rising edge.
//   out_* : one beat per input beat, in order, Q1.15 saturated.
//   cfg_* : writes the shortest-path bit; always ready. Write only while idle.
// Throughput: one beat per cycle while the pipeline is not stalled. The depth
//   is set mainly by the 20-step acos bisection (seven stages per step, each
//   with a six-stage sine unit), a six-stage sine for the weights and a
//   48-stage divider; each result is held in the output register.
// Stall: the whole pipeline holds while out_valid is high and out_ready is
//   low; in_ready then drops. Nothing is dropped or repeated.
// Reset: arst_n clears all valid bits and sets shortest path on.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  qs_pkg::in_t  in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output qs_pkg::out_t out_data
);

	localparam int NS = qs_pkg::ACOS_STEPS;
	localparam int SL = qs_pkg::SIN_LAT;
	localparam int DL = qs_pkg::DIV_LAT;

	logic adv;
	logic shortest_q;

	// ---------------- stage 1: clamp t, component products
	logic signed [15:0] pin [4];
	logic signed [15:0] qin [4];
	logic [16:0]        t_s1;
	logic signed [15:0] p_s1    [4];
	logic signed [15:0] q_s1    [4];
	logic signed [31:0] prod_s1 [4];
	logic               vld_s1;

	// ---------------- stage 2 / acos boundaries
	logic signed [33:0] dot_sum;
	logic signed [34:0] dot_f;
	logic signed [31:0] dot_c;
	logic               flip;
	qs_pkg::side_t      side_in;

	qs_pkg::side_t bnd_side_s [NS+1];
	logic [19:0]   bnd_a_s    [NS+1];
	logic          bnd_vld_s  [NS+1];
	logic [19:0]   bnd_arg_s  [NS];
	logic          bnd_neg_s  [NS];

	// ---------------- weight stages
	logic [36:0]   ap_prod, aq_prod;
	logic [37:0]   ap_rnd, aq_rnd;
	logic [19:0]   om_s3, ap_s3, aq_s3;
	qs_pkg::side_t side_s3;
	logic          vld_s3;

	logic [30:0]   so, sp, sq;
	qs_pkg::side_t sw_side_s [SL];
	logic          sw_vld_s  [SL];
	logic          use_slerp;

	logic [46:0]   quo_p, quo_q;
	qs_pkg::side_t dv_side_s [DL];
	logic          dv_use_s  [DL];
	logic          dv_vld_s  [DL];

	logic [30:0]   lin_p, lin_q;
	logic [46:0]   wp_s5, wq_s5;
	qs_pkg::side_t side_s5;
	logic          vld_s5;

	logic signed [41:0] pl_s6 [4];
	logic signed [41:0] ph_s6 [4];
	logic signed [41:0] ql_s6 [4];
	logic signed [41:0] qh_s6 [4];
	logic               vld_s6;

	logic signed [67:0] r_s7 [4];
	logic               vld_s7;

	logic signed [15:0] y [4];
	qs_pkg::out_t       out_s8;
	logic               vld_s8;

	assign adv       = !vld_s8 || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shortest_q <= 1'b1;
		end else if (cfg_valid) begin
			shortest_q <= cfg_data;
		end
	end

	assign pin[0] = in_data.start_q0;
	assign pin[1] = in_data.start_q1;
	assign pin[2] = in_data.start_q2;
	assign pin[3] = in_data.start_q3;
	assign qin[0] = in_data.end_q0;
	assign qin[1] = in_data.end_q1;
	assign qin[2] = in_data.end_q2;
	assign qin[3] = in_data.end_q3;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= (in_data.blend > qs_pkg::T_ONE) ? qs_pkg::T_ONE : in_data.blend;
			for (int c = 0; c < 4; c++) begin
				p_s1[c]    <= pin[c];
				q_s1[c]    <= qin[c];
				prod_s1[c] <= pin[c] * qin[c];
			end
		end
	end

	// ---------------- stage 2: dot product, path flip, clamp, branch
	always_comb begin
		dot_sum = 34'(prod_s1[0]) + 34'(prod_s1[1]) + 34'(prod_s1[2]) + 34'(prod_s1[3]);
		flip    = shortest_q && dot_sum < 0;
		dot_f   = flip ? -35'(dot_sum) : 35'(dot_sum);
		if (dot_f > 35'(qs_pkg::ONE30)) begin
			dot_c = 32'(qs_pkg::ONE30);
		end else if (dot_f < -35'(qs_pkg::ONE30)) begin
			dot_c = -32'(qs_pkg::ONE30);
		end else begin
			dot_c = 32'(dot_f);
		end
		side_in.t     = t_s1;
		side_in.dot   = dot_c;
		side_in.slerp = (qs_pkg::ONE30 - 34'(dot_c)) > qs_pkg::NEAR_LIMIT;
		for (int c = 0; c < 4; c++) begin
			side_in.p[c] = p_s1[c];
			side_in.q[c] = flip ? -17'(q_s1[c]) : 17'(q_s1[c]);
		end
	end

	// The first candidate is pi/2, whose cosine argument is zero
	always_ff @(posedge clk) begin
		if (adv) begin
			bnd_side_s[0] <= side_in;
			bnd_a_s[0]    <= '0;
			bnd_arg_s[0]  <= '0;
			bnd_neg_s[0]  <= 1'b0;
		end
	end

	// ---------------- acos bisection, one bit per step
	for (genvar i = 0; i < NS; i++) begin : g_acos
		localparam logic [19:0] BIT = 20'(1) << (NS - 1 - i);

		qs_pkg::side_t      dl_side_s [SL];
		logic [19:0]        dl_a_s    [SL];
		logic               dl_neg_s  [SL];
		logic               dl_vld_s  [SL];
		logic [30:0]        sine;
		logic signed [31:0] cosv;
		logic               keep;
		logic [19:0]        a_n;

		qs_sin u_sin (
			.clk   (clk),
			.en    (adv),
			.angle ({1'b0, bnd_arg_s[i]}),
			.sine  (sine)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int j = 0; j < SL; j++) dl_vld_s[j] <= 1'b0;
				bnd_vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				dl_vld_s[0] <= bnd_vld_s[i];
				for (int j = 1; j < SL; j++) dl_vld_s[j] <= dl_vld_s[j-1];
				bnd_vld_s[i+1] <= dl_vld_s[SL-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dl_side_s[0] <= bnd_side_s[i];
				dl_a_s[0]    <= bnd_a_s[i];
				dl_neg_s[0]  <= bnd_neg_s[i];
				for (int j = 1; j < SL; j++) begin
					dl_side_s[j] <= dl_side_s[j-1];
					dl_a_s[j]    <= dl_a_s[j-1];
					dl_neg_s[j]  <= dl_neg_s[j-1];
				end
			end
		end

		assign cosv = dl_neg_s[SL-1] ? -$signed({1'b0, sine}) : $signed({1'b0, sine});
		assign keep = cosv >= $signed(dl_side_s[SL-1].dot);
		assign a_n  = keep ? (dl_a_s[SL-1] | BIT) : dl_a_s[SL-1];

		always_ff @(posedge clk) begin
			if (adv) begin
				bnd_side_s[i+1] <= dl_side_s[SL-1];
				bnd_a_s[i+1]    <= a_n;
			end
		end

		if (i < NS - 1) begin : g_next
			localparam logic [19:0] NBIT = BIT >> 1;
			logic [19:0] cand;

			assign cand = a_n | NBIT;

			// cos(a) = sin(pi/2 - a) below pi/2, -sin(a - pi/2) above
			always_ff @(posedge clk) begin
				if (adv) begin
					if (cand <= qs_pkg::ANG_HALF) begin
						bnd_arg_s[i+1] <= qs_pkg::ANG_HALF - cand;
						bnd_neg_s[i+1] <= 1'b0;
					end else begin
						bnd_arg_s[i+1] <= cand - qs_pkg::ANG_HALF;
						bnd_neg_s[i+1] <= 1'b1;
					end
				end
			end
		end
	end

	// ---------------- stage 3: split omega by t
	assign ap_prod = 37'(qs_pkg::T_ONE - bnd_side_s[NS].t) * 37'(bnd_a_s[NS]);
	assign aq_prod = 37'(bnd_side_s[NS].t) * 37'(bnd_a_s[NS]);
	assign ap_rnd  = 38'(ap_prod) + 38'd32768;
	assign aq_rnd  = 38'(aq_prod) + 38'd32768;

	always_ff @(posedge clk) begin
		if (adv) begin
			om_s3   <= bnd_a_s[NS];
			ap_s3   <= ap_rnd[35:16];
			aq_s3   <= aq_rnd[35:16];
			side_s3 <= bnd_side_s[NS];
		end
	end

	qs_sin u_sin_om (.clk(clk), .en(adv), .angle({1'b0, om_s3}), .sine(so));
	qs_sin u_sin_p  (.clk(clk), .en(adv), .angle({1'b0, ap_s3}), .sine(sp));
	qs_sin u_sin_q  (.clk(clk), .en(adv), .angle({1'b0, aq_s3}), .sine(sq));

	always_ff @(posedge clk) begin
		if (adv) begin
			sw_side_s[0] <= side_s3;
			for (int j = 1; j < SL; j++) sw_side_s[j] <= sw_side_s[j-1];
		end
	end

	assign use_slerp = sw_side_s[SL-1].slerp && so != '0;

	qs_div u_div_p (.clk(clk), .en(adv), .num(sp), .den(so), .quo(quo_p));
	qs_div u_div_q (.clk(clk), .en(adv), .num(sq), .den(so), .quo(quo_q));

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_side_s[0] <= sw_side_s[SL-1];
			dv_use_s[0]  <= use_slerp;
			for (int j = 1; j < DL; j++) begin
				dv_side_s[j] <= dv_side_s[j-1];
				dv_use_s[j]  <= dv_use_s[j-1];
			end
		end
	end

	// ---------------- stage 5: pick weights
	assign lin_p = {qs_pkg::T_ONE - dv_side_s[DL-1].t, 14'b0};
	assign lin_q = {dv_side_s[DL-1].t, 14'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			wp_s5   <= dv_use_s[DL-1] ? quo_p : 47'(lin_p);
			wq_s5   <= dv_use_s[DL-1] ? quo_q : 47'(lin_q);
			side_s5 <= dv_side_s[DL-1];
		end
	end

	// ---------------- stage 6: partial products, weights cut at bit 24
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				pl_s6[c] <= $signed({1'b0, wp_s5[23:0]})  * $signed(side_s5.p[c]);
				ph_s6[c] <= $signed({1'b0, wp_s5[46:24]}) * $signed(side_s5.p[c]);
				ql_s6[c] <= $signed({1'b0, wq_s5[23:0]})  * $signed(side_s5.q[c]);
				qh_s6[c] <= $signed({1'b0, wq_s5[46:24]}) * $signed(side_s5.q[c]);
			end
		end
	end

	// ---------------- stage 7: Q.45 sum
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				r_s7[c] <= ((68'(ph_s6[c]) + 68'(qh_s6[c])) <<< 24)
					+ 68'(pl_s6[c]) + 68'(ql_s6[c]);
			end
		end
	end

	// ---------------- output: round, floor, saturate
	always_comb begin
		logic signed [67:0] rnd;
		logic signed [67:0] sh;
		for (int c = 0; c < 4; c++) begin
			rnd = r_s7[c] + 68'sd536870912;
			sh  = rnd >>> 30;
			if (sh > 68'sd32767) begin
				y[c] = 16'sd32767;
			end else if (sh < -68'sd32768) begin
				y[c] = -16'sd32768;
			end else begin
				y[c] = 16'(sh);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s8.out_q0 <= y[0];
			out_s8.out_q1 <= y[1];
			out_s8.out_q2 <= y[2];
			out_s8.out_q3 <= y[3];
		end
	end

	// ---------------- valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			bnd_vld_s[0] <= 1'b0;
			vld_s3       <= 1'b0;
			for (int j = 0; j < SL; j++) sw_vld_s[j] <= 1'b0;
			for (int j = 0; j < DL; j++) dv_vld_s[j] <= 1'b0;
			vld_s5       <= 1'b0;
			vld_s6       <= 1'b0;
			vld_s7       <= 1'b0;
			vld_s8       <= 1'b0;
		end else if (adv) begin
			vld_s1       <= in_valid;
			bnd_vld_s[0] <= vld_s1;
			vld_s3       <= bnd_vld_s[NS];
			sw_vld_s[0]  <= vld_s3;
			for (int j = 1; j < SL; j++) sw_vld_s[j] <= sw_vld_s[j-1];
			dv_vld_s[0]  <= sw_vld_s[SL-1];
			for (int j = 1; j < DL; j++) dv_vld_s[j] <= dv_vld_s[j-1];
			vld_s5       <= dv_vld_s[DL-1];
			vld_s6       <= vld_s5;
			vld_s7       <= vld_s6;
			vld_s8       <= vld_s7;
		end
	end

	assign out_valid = vld_s8;
	assign out_data  = out_s8;

endmodule

`default_nettype wire

// ===== tb/quaternion_slerp_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_slerp_tb: self-checking regression for the slerp block
// Streams quaternion pairs with random gaps and output stalls, predicts each
// blended quaternion in fixed point and compares every output beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp_tb;

	localparam int N_RANDOM = 1530;
	localparam int LATENCY  = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	qs_pkg::in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	qs_pkg::out_t out_data;

	bit   path_short = 1'b1;
	qs_pkg::out_t pending_q[$];
	int   mismatches = 0;
	int   beats_in = 0;
	int   beats_out = 0;
	bit   stim_done = 1'b0;

	typedef struct {
		bit           cfg;
		bit           cfg_val;
		qs_pkg::in_t  item;
		bit           known;
		qs_pkg::out_t result;
	} row_t;

	quaternion_slerp dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #4 clk = ~clk;

	// sine in Q.30 of a binary angle in [0, pi], 2^20 = pi
	function automatic longint sine_q30(longint a);
		longint unsigned z, z2, s;
		if (a < 0) a = 0;
		if (a > 64'd1048576) a = 1048576;
		if (a > 64'd524288) a = 1048576 - a;
		z = longint'(a) << 11;
		z2 = (z * z) >> 30;
		s = qs_pkg::C9;
		s = qs_pkg::C7 - ((z2 * s) >> 30);
		s = qs_pkg::C5 - ((z2 * s) >> 30);
		s = qs_pkg::C3 - ((z2 * s) >> 30);
		s = qs_pkg::C1 - ((z2 * s) >> 30);
		return longint'((z * s) >> 30);
	endfunction

	function automatic longint cosine_q30(longint a);
		if (a <= 524288) return sine_q30(524288 - a);
		return -sine_q30(a - 524288);
	endfunction

	function automatic longint arc_cosine(longint c);
		longint a, b;
		a = 0;
		for (b = 524288; b > 0; b = b >>> 1)
			if (cosine_q30(a + b) >= c) a += b;
		return a;
	endfunction

	function automatic qs_pkg::out_t blend_quat(qs_pkg::in_t x, bit shortp);
		longint p[4], q[4], dot, wp, wq, t, om, so, ap, aq, r;
		longint unsigned vp, vq;
		qs_pkg::out_t y;
		t = x.blend;
		if (t > 65536) t = 65536;
		p = '{x.start_q0, x.start_q1, x.start_q2, x.start_q3};
		q = '{x.end_q0, x.end_q1, x.end_q2, x.end_q3};
		dot = 0;
		for (int i = 0; i < 4; i++) dot += p[i] * q[i];
		if (shortp && dot < 0) begin
			dot = -dot;
			for (int i = 0; i < 4; i++) q[i] = -q[i];
		end
		if (dot > (64'sd1 <<< 30)) dot = 64'sd1 <<< 30;
		if (dot < -(64'sd1 <<< 30)) dot = -(64'sd1 <<< 30);
		wp = (65536 - t) <<< 14;
		wq = t <<< 14;
		if ((64'sd1 <<< 30) - dot > 98304) begin
			om = arc_cosine(dot);
			so = sine_q30(om);
			if (so > 0) begin
				ap = ((65536 - t) * om + 32768) >>> 16;
				aq = (t * om + 32768) >>> 16;
				vp = (longint'(sine_q30(ap)) << 30) / longint'(so);
				vq = (longint'(sine_q30(aq)) << 30) / longint'(so);
				wp = vp > (64'd1 << 46) ? (64'sd1 <<< 46) : longint'(vp);
				wq = vq > (64'd1 << 46) ? (64'sd1 <<< 46) : longint'(vq);
			end
		end
		for (int i = 0; i < 4; i++) begin
			r = (wp * p[i] + wq * q[i] + (64'sd1 <<< 29)) >>> 30;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			case (i)
				0: y.out_q0 = r[15:0];
				1: y.out_q1 = r[15:0];
				2: y.out_q2 = r[15:0];
				default: y.out_q3 = r[15:0];
			endcase
		end
		return y;
	endfunction

	task automatic report(string what, qs_pkg::out_t got, qs_pkg::out_t want);
		mismatches++;
		$display("mismatch %s at beat %0d: got %0d %0d %0d %0d want %0d %0d %0d %0d", what,
			beats_out, got.out_q0, got.out_q1, got.out_q2, got.out_q3,
			want.out_q0, want.out_q1, want.out_q2, want.out_q3);
	endtask

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// output side: random stalls, field compare against oldest expectation
	initial begin
		qs_pkg::out_t want;
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				beats_out++;
				if (pending_q.size() == 0) report("unexpected", out_data, '0);
				else begin
					want = pending_q.pop_front();
					if (out_data.out_q0 !== want.out_q0) report("q0", out_data, want);
					if (out_data.out_q1 !== want.out_q1) report("q1", out_data, want);
					if (out_data.out_q2 !== want.out_q2) report("q2", out_data, want);
					if (out_data.out_q3 !== want.out_q3) report("q3", out_data, want);
				end
			end
			if (stim_done) out_ready <= 1'b1;
			else if ((beats_in / 300) % 3 == 1) out_ready <= 1'b1;
			else if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				hold = gap_len();
				out_ready <= (hold == 0);
			end
		end
	end

	task automatic send_item(qs_pkg::in_t x, bit known, qs_pkg::out_t result);
		in_valid <= 1'b1;
		in_data <= x;
		do @(posedge clk); while (!in_ready);
		beats_in++;
		pending_q.insert(pending_q.size(), blend_quat(x, path_short));
		if (known && blend_quat(x, path_short) !== result) begin
			mismatches++;
			$display("predictor disagrees with table at item %0d", beats_in);
		end
		for (int g = gap_len(); g > 0; g--) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic write_path(bit v);
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		path_short = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic qs_pkg::in_t rand_unit(bit near);
		qs_pkg::in_t x;
		real a[4], b[4], n, m;
		for (int i = 0; i < 4; i++) a[i] = real'($urandom_range(0, 2000)) - 1000.0;
		n = 0;
		for (int i = 0; i < 4; i++) n += a[i] * a[i];
		if (n < 1) begin a[0] = 1; n = 1; end
		n = $sqrt(n);
		for (int i = 0; i < 4; i++) begin
			b[i] = near ? a[i] + real'($urandom_range(0, 40)) - 20.0
				: real'($urandom_range(0, 2000)) - 1000.0;
			if ($urandom_range(0, 5) == 0 && near) b[i] = -b[i];
		end
		m = 0;
		for (int i = 0; i < 4; i++) m += b[i] * b[i];
		if (m < 1) begin b[0] = 1; m = 1; end
		m = $sqrt(m);
		x.start_q0 = 16'($rtoi(a[0] / n * 32767.0));
		x.start_q1 = 16'($rtoi(a[1] / n * 32767.0));
		x.start_q2 = 16'($rtoi(a[2] / n * 32767.0));
		x.start_q3 = 16'($rtoi(a[3] / n * 32767.0));
		x.end_q0 = 16'($rtoi(b[0] / m * 32767.0));
		x.end_q1 = 16'($rtoi(b[1] / m * 32767.0));
		x.end_q2 = 16'($rtoi(b[2] / m * 32767.0));
		x.end_q3 = 16'($rtoi(b[3] / m * 32767.0));
		x.blend = 17'($urandom_range(0, 65536));
		return x;
	endfunction

	function automatic qs_pkg::in_t mk(int t, int a0, int a1, int a2, int a3,
			int b0, int b1, int b2, int b3);
		qs_pkg::in_t x;
		x.blend = 17'(t);
		x.start_q0 = 16'(a0); x.start_q1 = 16'(a1);
		x.start_q2 = 16'(a2); x.start_q3 = 16'(a3);
		x.end_q0 = 16'(b0); x.end_q1 = 16'(b1);
		x.end_q2 = 16'(b2); x.end_q3 = 16'(b3);
		return x;
	endfunction

	initial begin
		row_t rows[$];
		row_t r;
		qs_pkg::in_t x;
		qs_pkg::out_t o;
		// identical inputs with t at the ends: output is the input (unit rows take linear weights)
		r = '{0, 0, mk(0, 32767, 0, 0, 0, 32767, 0, 0, 0), 1, '{32767, 0, 0, 0}};
		rows.insert(rows.size(), r);
		r = '{0, 0, mk(65536, 0, 32767, 0, 0, 0, 32767, 0, 0), 1, '{0, 32767, 0, 0}};
		rows.insert(rows.size(), r);
		r = '{0, 0, mk(0, 1000, -2000, 300, 0, 1000, -2000, 300, 0), 1,
			'{1000, -2000, 300, 0}};
		rows.insert(rows.size(), r);
		// blend above one saturates
		r = '{0, 0, mk(131071, 0, 0, 32767, 0, 0, 0, 32767, 0), 1, '{0, 0, 32767, 0}};
		rows.insert(rows.size(), r);
		r.known = 0;
		r.item = mk(32768, 32767, 0, 0, 0, 0, 32767, 0, 0); rows.insert(rows.size(), r);
		r.item = mk(16384, 32767, 0, 0, 0, -32768, 0, 0, 0); rows.insert(rows.size(), r);
		r.item = mk(32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		rows.insert(rows.size(), r);
		r.item = mk(65535, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
		rows.insert(rows.size(), r);
		r.item = mk(1, 23170, 23170, 0, 0, 0, 23170, 23170, 0); rows.insert(rows.size(), r);
		r.item = mk(40000, 32767, 0, 0, 0, 32766, 100, 0, 0); rows.insert(rows.size(), r);
		r.item = mk(70000, 0, 0, 0, 0, 0, 0, 0, 0); rows.insert(rows.size(), r);
		r = '{1, 0, '0, 0, '0}; rows.insert(rows.size(), r);
		r.cfg = 0;
		r.item = mk(32768, 32767, 0, 0, 0, -32767, 300, 0, 0); rows.insert(rows.size(), r);
		r.item = mk(16384, 32767, 0, 0, 0, -32768, 0, 0, 0); rows.insert(rows.size(), r);
		r.item = mk(50000, 23170, 0, 23170, 0, -23170, 0, -23170, 10);
		rows.insert(rows.size(), r);
		r.item = mk(32768, 32767, 0, 0, 0, 0, 32767, 0, 0); rows.insert(rows.size(), r);
		r.item = mk(65536, -32768, 0, 0, 0, -32768, 0, 0, 0); rows.insert(rows.size(), r);
		r = '{1, 1, '0, 0, '0}; rows.insert(rows.size(), r);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].cfg) write_path(rows[i].cfg_val);
			else send_item(rows[i].item, rows[i].known, rows[i].result);
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 500) write_path(1'b0);
			if (n == 1000) write_path(1'b1);
			if (n == 750) begin
				in_valid <= 1'b0;
				while (pending_q.size() != 0) @(posedge clk);
			end
			case ($urandom_range(0, 9))
				0: begin
					x = qs_pkg::in_t'($bits(qs_pkg::in_t)'(
						{$urandom, $urandom, $urandom, $urandom, $urandom}));
				end
				1, 2: x = rand_unit(1'b1);
				default: x = rand_unit(1'b0);
			endcase
			if ($urandom_range(0, 30) == 0) x.blend = 17'h1ffff;
			send_item(x, 1'b0, o);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("ran %0d quaternion pairs, %0d results checked, both path modes",
			beats_in, beats_out);
		$display("included edge cases: saturated blend, -1.0 components, antipodal pairs");
		if (mismatches == 0 && pending_q.size() == 0)
			$display("quaternion_slerp regression: pass");
		else
			$display("quaternion_slerp regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("quaternion_slerp regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
